// ----- rtl/core/srd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite RLE decoder package
// Shared types and command codes for the sprite run-length decoder.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int CoordW = 16;
    localparam int RunW   = 7;
    localparam int ByteW  = 8;
    localparam int OutDataW = 48;

    localparam logic [ByteW-1:0] CMD_NEW_ROW = 8'h00;
    localparam logic [ByteW-1:0] CMD_END     = 8'h80;

    typedef struct packed {
        logic [CoordW-1:0] column;
        logic [CoordW-1:0] row;
        logic [RunW-1:0]   literals_due;
        logic              stopped;
    } t_state;

    typedef struct packed {
        logic              pixel_valid;
        logic              is_mono_run;
        logic [CoordW-1:0] pixel_x;
        logic [CoordW-1:0] pixel_y;
        logic [RunW-1:0]   run_length;
        logic [ByteW-1:0]  color_index;
        logic              sprite_end;
    } t_result;

    function automatic logic [CoordW-1:0] sat_add(
        input logic [CoordW-1:0] a,
        input logic [RunW-1:0]   b
    );
        logic [CoordW:0] s;
        s = {1'b0, a} + {{(CoordW + 1 - RunW){1'b0}}, b};
        return s[CoordW] ? {CoordW{1'b1}} : s[CoordW-1:0];
    endfunction

endpackage

// ----- rtl/core/srd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite RLE byte decoder
// Decodes one coded byte against the current drawing state and gives the
// next state and the result beat, if any.
// ----------------------------------------------------------------------------
module srd_decode (
    input  srd_pkg::t_state           i_state,
    input  logic [srd_pkg::ByteW-1:0] i_byte,
    input  logic                      i_last,
    input  logic                      i_mono,
    output srd_pkg::t_state           o_state,
    output srd_pkg::t_result          o_result,
    output logic                      o_has_result
);
    import srd_pkg::*;

    t_state  n_state;
    t_result n_res;

    always_comb begin
        n_state = i_state;
        n_res   = '0;
        if (!i_state.stopped) begin
            if (i_state.literals_due != '0) begin
                n_res.pixel_valid    = 1'b1;
                n_res.pixel_x        = i_state.column;
                n_res.pixel_y        = i_state.row;
                n_res.run_length     = RunW'(1);
                n_res.color_index    = i_byte;
                n_state.column       = sat_add(i_state.column, RunW'(1));
                n_state.literals_due = i_state.literals_due - RunW'(1);
            end else if (i_byte == CMD_NEW_ROW) begin
                n_state.column = '0;
                n_state.row    = sat_add(i_state.row, RunW'(1));
            end else if (i_byte == CMD_END) begin
                n_state.stopped = 1'b1;
            end else if (!i_byte[ByteW-1]) begin
                if (i_mono) begin
                    n_res.pixel_valid = 1'b1;
                    n_res.is_mono_run = 1'b1;
                    n_res.pixel_x     = i_state.column;
                    n_res.pixel_y     = i_state.row;
                    n_res.run_length  = i_byte[RunW-1:0];
                    n_state.column    = sat_add(i_state.column, i_byte[RunW-1:0]);
                end else begin
                    n_state.literals_due = i_byte[RunW-1:0];
                end
            end else begin
                n_state.column = sat_add(i_state.column, i_byte[RunW-1:0]);
            end
        end
        n_res.sprite_end = i_last;
        if (i_last) begin
            n_state = '0;
        end
    end

    assign o_state      = n_state;
    assign o_result     = n_res;
    assign o_has_result = n_res.pixel_valid | i_last;

endmodule

// ----- rtl/core/sprite_rle_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite RLE decoder
// Turns a stream of run-length-coded sprite bytes into pixel and run beats.
// ----------------------------------------------------------------------------
// The slave channel takes one coded byte per beat, with tlast on the final
// byte of a sprite's data segment. The master channel gives one beat for each
// byte that draws a pixel or a mono run, and one for the segment's last
// byte, which carries tlast. Other bytes only update column, row, the stopped
// flag or the literal count and give no beat.
// A byte goes to an input register and is decoded from there into the output
// register, which gives the result beat; the decode itself is combinational.
// One byte is taken in every cycle while the receiver keeps up; the decode of
// one byte against the stored state sets that figure.
// When the receiver stalls, the output register holds its beat, bytes that
// give no beat still pass, the next byte that gives a beat waits in the input
// register, and s_axis_tready drops until the output drains.
// The configuration channel writes the mono mode bit and is always ready; the
// user must write it only while the decoder is idle; it is not enforced.
// Reset clears column, row, literal count, stopped flag, mono mode and the
// valid flags of both pipeline registers.
// ----------------------------------------------------------------------------
module sprite_rle_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // data_byte
    input  logic [srd_pkg::ByteW-1:0]    s_axis_tdata,
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // pixel_x, pixel_y, run_length, color_index, zero pad
    output logic [srd_pkg::OutDataW-1:0] m_axis_tdata,
    // pixel_valid, is_mono_run
    output logic [1:0]                   m_axis_tuser,
    output logic                         m_axis_tlast
);
    import srd_pkg::*;

    logic             r_mono;
    t_state           r_state;
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_last;
    logic             r_out_valid;
    t_result          r_out;

    t_state  n_state;
    t_result n_result;
    logic    has_result;
    logic    out_free;
    logic    advance;

    srd_decode u_decode (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_mono       (r_mono),
        .o_state      (n_state),
        .o_result     (n_result),
        .o_has_result (has_result)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (out_free || !has_result);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mono <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance && has_result) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance && has_result) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.color_index, r_out.run_length,
                            r_out.pixel_y, r_out.pixel_x};
    assign m_axis_tuser  = {r_out.is_mono_run, r_out.pixel_valid};
    assign m_axis_tlast  = r_out.sprite_end;

endmodule

// ----- verif/tb_sprite_rle_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite RLE decoder testbench
// Streams coded sprite bytes into the decoder under several idle and stall
// patterns and both mono mode settings. Each accepted byte is decoded by a
// behavioral model in the bench, and every result beat is checked field by
// field against the oldest expected beat. Directed bytes cover commands used
// as literal indexes, the end command, trailing ignored bytes, a segment that
// ends inside a literal run and column saturation.
// ----------------------------------------------------------------------------
module tb_sprite_rle_decoder;

    import srd_pkg::*;

    localparam logic [ByteW-1:0]  MAX_RUN   = 8'h7F;
    localparam int unsigned       COORD_MAX = 65535;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
    } t_coded_byte;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_data    = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [ByteW-1:0]    s_axis_tdata  = '0;
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                m_axis_tlast;

    t_coded_byte pending_bytes[$];
    t_result     expected_beats[$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_left      = 0;
    int          pushed         = 0;
    int          errors_seen    = 0;

    logic [CoordW-1:0] col_q      = '0;
    logic [CoordW-1:0] row_q      = '0;
    logic [RunW-1:0]   lits_due_q = '0;
    logic              halted_q   = 1'b0;
    logic              mono_q     = 1'b0;

    sprite_rle_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [CoordW-1:0] coord_plus(input logic [CoordW-1:0] a,
                                                     input logic [RunW-1:0] n);
        int unsigned sum;
        sum = a + n;
        return (sum > COORD_MAX) ? CoordW'(COORD_MAX) : CoordW'(sum);
    endfunction

    task automatic decode_byte(input logic [ByteW-1:0] b, input logic last);
        t_result beat;
        logic    draws;
        beat  = '0;
        draws = 1'b0;
        if (!halted_q) begin
            if (lits_due_q != 0) begin
                draws            = 1'b1;
                beat.pixel_x     = col_q;
                beat.pixel_y     = row_q;
                beat.run_length  = RunW'(1);
                beat.color_index = b;
                col_q            = coord_plus(col_q, RunW'(1));
                lits_due_q       = lits_due_q - RunW'(1);
            end else if (b == CMD_NEW_ROW) begin
                col_q = '0;
                row_q = coord_plus(row_q, RunW'(1));
            end else if (b == CMD_END) begin
                halted_q = 1'b1;
            end else if (b <= MAX_RUN) begin
                if (mono_q) begin
                    draws           = 1'b1;
                    beat.is_mono_run = 1'b1;
                    beat.pixel_x    = col_q;
                    beat.pixel_y    = row_q;
                    beat.run_length = b[RunW-1:0];
                    col_q           = coord_plus(col_q, b[RunW-1:0]);
                end else begin
                    lits_due_q = b[RunW-1:0];
                end
            end else begin
                col_q = coord_plus(col_q, b[RunW-1:0]);
            end
        end
        if (draws || last) begin
            beat.pixel_valid = draws;
            beat.sprite_end  = last;
            expected_beats.insert(expected_beats.size(), beat);
        end
        if (last) begin
            col_q      = '0;
            row_q      = '0;
            lits_due_q = '0;
            halted_q   = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors_seen++;
        end
    endtask

    // Sender: a new beat is offered only once the previous one was taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                {s_axis_tdata, s_axis_tlast} <= pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with no expected beat waiting");
                    errors_seen++;
                end else begin
                    t_result want;
                    want = expected_beats.pop_front();
                    check_field("pixel_valid", 32'(want.pixel_valid), 32'(m_axis_tuser[0]));
                    check_field("is_mono_run", 32'(want.is_mono_run), 32'(m_axis_tuser[1]));
                    check_field("pixel_x", 32'(want.pixel_x), 32'(m_axis_tdata[15:0]));
                    check_field("pixel_y", 32'(want.pixel_y), 32'(m_axis_tdata[31:16]));
                    check_field("run_length", 32'(want.run_length),
                                32'(m_axis_tdata[38:32]));
                    check_field("color_index", 32'(want.color_index),
                                32'(m_axis_tdata[46:39]));
                    check_field("sprite_end", 32'(want.sprite_end), 32'(m_axis_tlast));
                end
            end
        end
    end

    task automatic push_byte(input logic [ByteW-1:0] d, input logic l);
        pending_bytes.insert(pending_bytes.size(), {d, l});
        pushed++;
    endtask

    task automatic write_mono(input logic v);
        @(posedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        mono_q = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_beats.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    // A mostly well-formed sprite; some end on a pixel or are cut off mid-run.
    task automatic add_sprite(input logic mono);
        t_coded_byte body[$];
        int          cmds;
        int          kind;
        int          len;
        int          ending;
        int          cut;
        cmds = $urandom_range(1, 12);
        for (int i = 0; i < cmds; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                body.insert(body.size(), {CMD_NEW_ROW, 1'b0});
            end else if (kind < 5) begin
                body.insert(body.size(), {ByteW'($urandom_range(129, 255)), 1'b0});
            end else begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 127)
                                                   : $urandom_range(1, 8);
                body.insert(body.size(), {ByteW'(len), 1'b0});
                if (!mono) begin
                    repeat (len) begin
                        body.insert(body.size(), {ByteW'($urandom_range(0, 255)), 1'b0});
                    end
                end
            end
        end
        ending = $urandom_range(0, 19);
        if (ending < 12) begin
            body.insert(body.size(), {CMD_END, 1'b0});
            repeat ($urandom_range(0, 3)) begin
                body.insert(body.size(), {ByteW'($urandom_range(0, 255)), 1'b0});
            end
        end else if (ending >= 16) begin
            cut  = $urandom_range(0, body.size() - 1);
            body = body[0:cut];
        end
        body[body.size() - 1].last = 1'b1;
        foreach (body[i]) push_byte(body[i].data, body[i].last);
    endtask

    // Walks the column to its ceiling.
    task automatic add_far_sprite(input logic mono);
        repeat (516) push_byte(8'hFF, 1'b0);
        push_byte(8'h05, 1'b0);
        if (mono) begin
            push_byte(8'h03, 1'b0);
        end else begin
            repeat (5) push_byte(ByteW'($urandom_range(0, 255)), 1'b0);
        end
        push_byte(8'hC0, 1'b0);
        push_byte(8'h02, 1'b0);
        if (!mono) begin
            push_byte(8'h3C, 1'b0);
            push_byte(8'hC3, 1'b0);
        end
        push_byte(CMD_END, 1'b1);
    endtask

    task automatic add_random(input int count);
        int goal;
        goal = pushed + count;
        while (pushed < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                push_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                add_sprite(mono_q);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mono(1'b0);

        @(negedge i_clk);
        push_byte(8'h03, 1'b0);
        push_byte(CMD_NEW_ROW, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(CMD_END, 1'b0);
        push_byte(8'h81, 1'b0);
        push_byte(CMD_NEW_ROW, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(CMD_END, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(CMD_NEW_ROW, 1'b1);
        push_byte(8'h02, 1'b0);
        push_byte(8'h11, 1'b1);
        push_byte(MAX_RUN, 1'b1);
        add_far_sprite(1'b0);
        add_random(90);
        push_byte(CMD_NEW_ROW, 1'b1);
        push_byte(8'h02, 1'b0);
        push_byte(8'h10, 1'b0);
        wait_drained();

        // The literal run left open above must still take the next byte as
        // an index even though mono mode is now on.
        write_mono(1'b1);
        send_idle_pct = 46;
        @(negedge i_clk);
        push_byte(8'h20, 1'b0);
        push_byte(MAX_RUN, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(CMD_END, 1'b0);
        push_byte(8'hFF, 1'b1);
        add_far_sprite(1'b1);
        add_random(90);
        wait_drained();

        write_mono(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        @(negedge i_clk);
        add_random(90);
        hold_left = 400;
        wait_drained();

        write_mono(1'b1);
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        @(negedge i_clk);
        add_random(90);
        wait_drained();

        write_mono(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        add_random(90);
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (expected_beats.size() != 0) begin
            $error("%0d expected beats never arrived", expected_beats.size());
            errors_seen++;
        end
        if (errors_seen == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
